@@ rtl/uttb_pkg.sv @@
// Shared types and constants for the UUID text parser.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package uttb_pkg;

  localparam int unsigned CountWidth = 6;

  localparam logic [CountWidth-1:0] LONG_LEN  = 6'd36;
  localparam logic [CountWidth-1:0] SHORT_LEN = 6'd4;
  localparam logic [CountWidth-1:0] COUNT_SAT = 6'd37;

  localparam logic [CountWidth-1:0] HYPHEN_POS_A = 6'd8;
  localparam logic [CountWidth-1:0] HYPHEN_POS_B = 6'd13;
  localparam logic [CountWidth-1:0] HYPHEN_POS_C = 6'd18;
  localparam logic [CountWidth-1:0] HYPHEN_POS_D = 6'd23;

  localparam logic [7:0] HYPHEN_CHAR = 8'h2D;

  // Bluetooth base UUID pieces for the short form.
  localparam logic [63:0] BASE_LOW       = 64'h8000_0080_5F9B_34FB;
  localparam logic [31:0] BASE_HIGH_TAIL = 32'h0000_1000;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_LENGTH = 2'd1,
    STATUS_HYPHEN = 2'd2,
    STATUS_HEX    = 2'd3
  } status_t;

  typedef struct packed {
    logic       is_hex;
    logic       is_hyphen;
    logic [3:0] nibble;
  } char_info_t;

  typedef struct packed {
    logic [63:0] lo_word;
    logic [63:0] hi_word;
    status_t     status;
  } result_pair_t;

endpackage

`default_nettype wire

@@ rtl/uttb_char_decode.sv @@
// Classifies one ASCII character as hex digit or hyphen and gives its nibble.
// Depends on uttb_pkg.
`default_nettype none

module uttb_char_decode (
  input  wire logic [7:0]          char_code,
  output uttb_pkg::char_info_t     info
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  always_comb begin
    is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);
    is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);

    info.is_hex    = is_digit || is_upper || is_lower;
    info.is_hyphen = (char_code == uttb_pkg::HYPHEN_CHAR);
    // Letters 'A'/'a' have low nibble 1, so adding nine gives ten.
    if (is_digit) begin
      info.nibble = char_code[3:0];
    end else begin
      info.nibble = char_code[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uttb_accum.sv @@
// Per-string parser state: character count, error flags and 128-bit value.
// Depends on uttb_pkg and uttb_char_decode.
`default_nettype none

module uttb_accum (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            char_code,
  input  wire logic                  last_char,
  input  wire logic                  short_form,
  output uttb_pkg::result_pair_t     pair
);

  uttb_pkg::char_info_t info;

  logic [uttb_pkg::CountWidth-1:0] char_count;
  logic [uttb_pkg::CountWidth-1:0] char_count_next;
  logic [127:0]                    value;
  logic [127:0]                    value_next;
  logic                            hyphen_error;
  logic                            hyphen_error_next;
  logic                            hex_error;
  logic                            hex_error_next;
  logic                            form_latched;
  logic                            form_latched_next;

  logic [uttb_pkg::CountWidth-1:0] expect_len;
  logic                            hyphen_pos;

  uttb_char_decode u_decode (
    .char_code (char_code),
    .info      (info)
  );

  always_comb begin
    form_latched_next = (char_count == '0) ? short_form : form_latched;
    expect_len        = form_latched_next ? uttb_pkg::SHORT_LEN : uttb_pkg::LONG_LEN;
    hyphen_pos        = !form_latched_next &&
                        ((char_count == uttb_pkg::HYPHEN_POS_A) ||
                         (char_count == uttb_pkg::HYPHEN_POS_B) ||
                         (char_count == uttb_pkg::HYPHEN_POS_C) ||
                         (char_count == uttb_pkg::HYPHEN_POS_D));

    hyphen_error_next = hyphen_error;
    hex_error_next    = hex_error;
    value_next        = value;
    if (char_count < expect_len) begin
      if (hyphen_pos) begin
        if (!info.is_hyphen) begin
          hyphen_error_next = 1'b1;
        end
      end else if (!info.is_hex) begin
        hex_error_next = 1'b1;
      end else begin
        value_next = {value[123:0], info.nibble};
      end
    end

    if (char_count < uttb_pkg::COUNT_SAT) begin
      char_count_next = char_count + 6'd1;
    end else begin
      char_count_next = char_count;
    end

    // Length errors win over hyphen errors, hyphen errors over hex errors.
    if (char_count_next != expect_len) begin
      pair.status = uttb_pkg::STATUS_LENGTH;
    end else if (hyphen_error_next) begin
      pair.status = uttb_pkg::STATUS_HYPHEN;
    end else if (hex_error_next) begin
      pair.status = uttb_pkg::STATUS_HEX;
    end else begin
      pair.status = uttb_pkg::STATUS_OK;
    end

    if (pair.status != uttb_pkg::STATUS_OK) begin
      pair.lo_word = '0;
      pair.hi_word = '0;
    end else if (form_latched_next) begin
      pair.lo_word = uttb_pkg::BASE_LOW;
      pair.hi_word = {16'h0000, value_next[15:0], uttb_pkg::BASE_HIGH_TAIL};
    end else begin
      pair.lo_word = value_next[63:0];
      pair.hi_word = value_next[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      value        <= '0;
      hyphen_error <= 1'b0;
      hex_error    <= 1'b0;
      form_latched <= 1'b0;
    end else if (step) begin
      if (last_char) begin
        char_count   <= '0;
        value        <= '0;
        hyphen_error <= 1'b0;
        hex_error    <= 1'b0;
        form_latched <= 1'b0;
      end else begin
        char_count   <= char_count_next;
        value        <= value_next;
        hyphen_error <= hyphen_error_next;
        hex_error    <= hex_error_next;
        form_latched <= form_latched_next;
      end
    end
  end

  property p_count_bounded;
    @(posedge clk) disable iff (rst) char_count <= uttb_pkg::COUNT_SAT;
  endproperty
  a_count_bounded: assert property (p_count_bounded)
    else $error("character count passed its saturation value");

  property p_restart_after_last;
    @(posedge clk) disable iff (rst)
      (step && last_char) |=> (char_count == '0) && !hyphen_error && !hex_error;
  endproperty
  a_restart_after_last: assert property (p_restart_after_last)
    else $error("parser state not cleared after the final character");

endmodule

`default_nettype wire

@@ rtl/uttb_out_queue.sv @@
// Holds one finished result pair and sends the low word, then the high word.
// Depends on uttb_pkg.
`default_nettype none

module uttb_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire uttb_pkg::result_pair_t pair,
  output logic                       can_load,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [63:0]                uuid_word,
  output logic                       upper_half,
  output logic [1:0]                 status
);

  uttb_pkg::result_pair_t held;
  logic                   occupied;
  logic                   phase;
  logic                   transfer;

  assign transfer   = occupied && !out_stall;
  // A new pair may enter as the high word of the current one leaves.
  assign can_load   = !occupied || (transfer && phase);
  assign out_valid  = occupied;
  assign upper_half = phase;
  assign uuid_word  = phase ? held.hi_word : held.lo_word;
  assign status     = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      phase    <= 1'b0;
    end else if (load) begin
      occupied <= 1'b1;
      phase    <= 1'b0;
    end else if (transfer) begin
      if (phase) begin
        occupied <= 1'b0;
        phase    <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= pair;
    end
  end

  property p_high_follows_low;
    @(posedge clk) disable iff (rst)
      (transfer && !phase) |=> occupied && phase;
  endproperty
  a_high_follows_low: assert property (p_high_follows_low)
    else $error("high word did not follow the low word");

  property p_error_word_zero;
    @(posedge clk) disable iff (rst)
      (occupied && held.status != uttb_pkg::STATUS_OK) |-> (uuid_word == '0);
  endproperty
  a_error_word_zero: assert property (p_error_word_zero)
    else $error("nonzero word sent with an error status");

endmodule

`default_nettype wire

@@ rtl/uuid_text_to_binary_parser_unit.sv @@
// Top level of the UUID text parser: input register, parser state, output pair.
// Depends on uttb_pkg, uttb_accum and uttb_out_queue.
//
// Usage: the sender presents one character per transfer on char_code, with
// last_char set on the final character and short_form (sampled only on the
// first character of a string) choosing the 4-digit form over the 36-char
// dashed form. A transfer happens at a rising edge where in_valid is high and
// in_stall is low. Each character enters a one-deep input register, from which
// the parser updates its count, error flags and 128-bit value.
// On the final character the block produces two result transfers on the
// output channel: the low 64 bits (upper_half = 0) and then the high 64 bits
// (upper_half = 1), both with the same status. The final character passes
// through the input register and the output pair register before its low word
// appears. Throughput is one character per cycle while in_stall is low; the
// output takes a new pair only as the high word of the current one leaves.
// When the receiver raises out_stall, the held result stays put, a waiting
// final character is held in the input register and in_stall rises. Other
// characters keep flowing while a result waits. Synchronous reset clears the
// input register, the parser state and the output pair; no result survives.
`default_nettype none

module uuid_text_to_binary_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_char,
  input  wire logic        short_form,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      uuid_word,
  output logic             upper_half,
  output logic [1:0]       status
);

  logic       in_full;
  logic [7:0] char_q;
  logic       last_q;
  logic       short_q;
  logic       step;
  logic       can_load;
  logic       in_take;

  uttb_pkg::result_pair_t pair;

  // The held character moves on unless it ends a string and the output is busy.
  assign step     = in_full && (!last_q || can_load);
  assign in_stall = in_full && !step;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_q  <= char_code;
      last_q  <= last_char;
      short_q <= short_form;
    end
  end

  uttb_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_code  (char_q),
    .last_char  (last_q),
    .short_form (short_q),
    .pair       (pair)
  );

  uttb_out_queue u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step && last_q),
    .pair       (pair),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .uuid_word  (uuid_word),
    .upper_half (upper_half),
    .status     (status)
  );

  property p_stall_needs_held;
    @(posedge clk) disable iff (rst) in_stall |-> in_full && last_q;
  endproperty
  a_stall_needs_held: assert property (p_stall_needs_held)
    else $error("input stalled without a held final character");

  property p_final_loads_output;
    @(posedge clk) disable iff (rst) (step && last_q) |=> out_valid && !upper_half;
  endproperty
  a_final_loads_output: assert property (p_final_loads_output)
    else $error("final character did not start a result pair");

endmodule

`default_nettype wire
